[rtl/csss_pkg.sv]
// Shared types, constants and helper functions for the seven-segment clock scanner.
// Used by csss_time_conv and clock_seven_segment_scanner_unit; no dependencies.
package csss_pkg;

	// Display geometry
	localparam int DIGIT_COUNT = 6;
	localparam int SLOT_W      = 3;

	// Reciprocals for exact division by constants (multiply, then shift)
	// v / 100 for v below 2^27: shift 34
	localparam logic [27:0] RCP_100_W27 = 28'd171798692;
	// v / 100 for v below 2^21: shift 28
	localparam logic [21:0] RCP_100_W21 = 22'd2684355;
	// v / 100 for v below 2^14: shift 21
	localparam logic [14:0] RCP_100_W14 = 15'd20972;
	// v / 10 for v below 2^7: shift 11
	localparam logic [7:0]  RCP_10_W7   = 8'd205;
	// v / 24 for v below 2^8: shift 13
	localparam logic [8:0]  RCP_24_W8   = 9'd342;

	// Register reset values
	localparam logic [4:0]  TIME_ZONE_RST    = 5'd0;
	localparam logic        COLON_ENABLE_RST = 1'b1;
	localparam logic [15:0] SCAN_DIVIDER_RST = 16'd100;

	// Configuration register index (byte address / 4)
	typedef enum logic [1:0] {
		REG_TIME_ZONE    = 2'd0,
		REG_COLON_ENABLE = 2'd1,
		REG_SCAN_DIVIDER = 2'd2
	} reg_idx_t;

	// Input beat kind
	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	// Converted item leaving the conversion pipeline
	typedef struct packed {
		cmd_t                         cmd;
		logic [4:0]                   hours;
		logic [6:0]                   minutes;
		logic [6:0]                   seconds;
		logic [DIGIT_COUNT-1:0][3:0]  digits;
	} conv_t;

	// Tens of a value below 128
	function automatic logic [3:0] div10(input logic [6:0] x);
		logic [17:0] p;
		p = 18'(x) * 18'(RCP_10_W7);
		return p[14:11];
	endfunction

	// Value below 256 modulo 24
	function automatic logic [4:0] mod24(input logic [7:0] x);
		logic [16:0] p;
		logic [3:0]  q;
		logic [7:0]  r;
		p = 17'(x) * 17'(RCP_24_W8);
		q = p[16:13];
		r = x - 8'(8'(q) * 8'd24);
		return r[4:0];
	endfunction

	// Segment pattern a..g for one decimal digit; blank for other codes
	function automatic logic [6:0] seg_pattern(input logic [3:0] d);
		logic [6:0] s;
		unique case (d)
			4'd0:    s = 7'b0111111;
			4'd1:    s = 7'b0000110;
			4'd2:    s = 7'b1011011;
			4'd3:    s = 7'b1001111;
			4'd4:    s = 7'b1100110;
			4'd5:    s = 7'b1101101;
			4'd6:    s = 7'b1111101;
			4'd7:    s = 7'b0000111;
			4'd8:    s = 7'b1111111;
			4'd9:    s = 7'b1101111;
			default: s = 7'b0000000;
		endcase
		return s;
	endfunction

endpackage

[rtl/csss_time_conv.sv]
// Seven-stage conversion pipeline: decimal-coded hhmmsscc to zone-adjusted
// hours, minutes, seconds and six display digits. Depends on csss_pkg.
module csss_time_conv (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  csss_pkg::cmd_t       in_cmd,
	input  logic [26:0]          in_value,
	input  logic [4:0]           time_zone,
	output logic                 out_valid,
	input  logic                 out_ready,
	output csss_pkg::conv_t      out_item
);
	import csss_pkg::*;

	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	logic [26:0] val_s1;
	logic [20:0] q2_s2, q2_s3;
	logic [13:0] q4_s3, q4_s4;
	logic [7:0]  q6_s4;
	logic [6:0]  sec_s4, sec_s5, sec_s6;
	logic [6:0]  min_s5, min_s6;
	logic [7:0]  hsum_s5;
	logic [3:0]  sec_t_s5, sec_u_s5, sec_t_s6, sec_u_s6;
	logic [3:0]  min_t_s6, min_u_s6;
	logic [4:0]  hours_s6;
	conv_t       item_s7;

	logic [54:0] prod2;
	logic [42:0] prod3;
	logic [28:0] prod4;
	logic [6:0]  sec_c, min_c;
	logic [7:0]  hsum_c;
	logic [3:0]  sec_t_c, sec_u_c, min_t_c, min_u_c, hour_t_c, hour_u_c;
	logic [4:0]  hours_c;

	// Stage enables: a stage loads when empty or when the next one moves
	assign en_s7    = !vld_s7 || out_ready;
	assign en_s6    = !vld_s6 || en_s7;
	assign en_s5    = !vld_s5 || en_s6;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	// Stage 2: value / 100
	always_comb begin
		prod2 = 55'(val_s1) * 55'(RCP_100_W27);
	end

	// Stage 3: value / 10000
	always_comb begin
		prod3 = 43'(q2_s2) * 43'(RCP_100_W21);
	end

	// Stage 4: value / 1000000, seconds
	always_comb begin
		prod4 = 29'(q4_s3) * 29'(RCP_100_W14);
		sec_c = 7'(q2_s3 - 21'(21'(q4_s3) * 21'd100));
	end

	// Stage 5: minutes, zone sum, seconds digits
	always_comb begin
		min_c   = 7'(q4_s4 - 14'(14'(q6_s4) * 14'd100));
		hsum_c  = q6_s4 + 8'(time_zone);
		sec_t_c = div10(sec_s4);
		sec_u_c = 4'(sec_s4 - 7'(7'(sec_t_c) * 7'd10));
	end

	// Stage 6: hours modulo 24, minutes digits
	always_comb begin
		hours_c = mod24(hsum_s5);
		min_t_c = div10(min_s5);
		min_u_c = 4'(min_s5 - 7'(7'(min_t_c) * 7'd10));
	end

	// Stage 7: hours digits
	always_comb begin
		hour_t_c = div10(7'(hours_s6));
		hour_u_c = 4'(hours_s6 - 5'(5'(hour_t_c) * 5'd10));
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1 <= in_cmd;
			val_s1 <= in_value;
		end
		if (en_s2) begin
			cmd_s2 <= cmd_s1;
			q2_s2  <= prod2[54:34];
		end
		if (en_s3) begin
			cmd_s3 <= cmd_s2;
			q2_s3  <= q2_s2;
			q4_s3  <= prod3[41:28];
		end
		if (en_s4) begin
			cmd_s4 <= cmd_s3;
			q4_s4  <= q4_s3;
			q6_s4  <= prod4[28:21];
			sec_s4 <= sec_c;
		end
		if (en_s5) begin
			cmd_s5   <= cmd_s4;
			min_s5   <= min_c;
			hsum_s5  <= hsum_c;
			sec_s5   <= sec_s4;
			sec_t_s5 <= sec_t_c;
			sec_u_s5 <= sec_u_c;
		end
		if (en_s6) begin
			cmd_s6   <= cmd_s5;
			hours_s6 <= hours_c;
			min_s6   <= min_s5;
			min_t_s6 <= min_t_c;
			min_u_s6 <= min_u_c;
			sec_s6   <= sec_s5;
			sec_t_s6 <= sec_t_s5;
			sec_u_s6 <= sec_u_s5;
		end
		if (en_s7) begin
			item_s7.cmd       <= cmd_s6;
			item_s7.hours     <= hours_s6;
			item_s7.minutes   <= min_s6;
			item_s7.seconds   <= sec_s6;
			item_s7.digits[0] <= hour_t_c;
			item_s7.digits[1] <= hour_u_c;
			item_s7.digits[2] <= min_t_s6;
			item_s7.digits[3] <= min_u_s6;
			item_s7.digits[4] <= sec_t_s6;
			item_s7.digits[5] <= sec_u_s6;
		end
	end

	assign out_valid = vld_s7;
	assign out_item  = item_s7;

endmodule

[rtl/clock_seven_segment_scanner_unit.sv]
// Seven-segment clock scanner: top level with APB registers, display state
// and result register. Depends on csss_pkg and csss_time_conv.
//
// Usage:
//   Slave channel s_*: one beat per item. s_tuser = 1 loads the decimal-coded
//   time hhmmsscc in s_tdata; s_tuser = 0 is a scan tick that advances the
//   prescaler and, once past scan_divider, drives the next digit or wraps.
//   Master channel m_*: exactly one beat per input beat, carrying the drive
//   and the stored time after that item.
//   An input beat passes seven conversion stages (divisions by 100 done as
//   reciprocal multiplies, one per stage) and the result register, where
//   the display state is updated.
//   Throughput is one item per cycle while the receiver takes results; every
//   stage carries its own valid bit, so bubbles close up while the receiver
//   stalls; input is refused only once all stages and the output hold items.
//   APB registers: 0x0 time_zone, 0x4 colon_enable, 0x8 scan_divider; write
//   them only while no item is in flight.
//   Reset clears all stages, the digits, time fields, prescaler, scan slot
//   and drive; registers return to zone 0, colon enabled, divider 100.
module clock_seven_segment_scanner_unit (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [26:0] time_value, [31:27] zero
	input  logic        s_tuser,   // [0] command
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [7:0] segments, [13:8] digit_enable,
	                               // [18:14] hours, [25:19] minutes,
	                               // [32:26] seconds, [39:33] zero
);
	import csss_pkg::*;

	logic [4:0]  time_zone_q;
	logic        colon_enable_q;
	logic [15:0] scan_divider_q;

	logic        conv_valid;
	conv_t       conv_item;
	logic        en_out;
	logic        upd;
	logic        cfg_wr;

	logic        out_vld_q;
	logic [3:0]  digit_q [DIGIT_COUNT];
	logic        colon_q;
	logic [4:0]  hour_q;
	logic [6:0]  minute_q;
	logic [6:0]  second_q;
	logic [SLOT_W-1:0] slot_q;
	logic [15:0] tick_q;
	logic [7:0]  segment_q;
	logic [5:0]  enable_q;

	logic [15:0] tick_nx;
	logic        scan_step;
	logic [3:0]  scan_digit;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_zone_q    <= TIME_ZONE_RST;
			colon_enable_q <= COLON_ENABLE_RST;
			scan_divider_q <= SCAN_DIVIDER_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_TIME_ZONE:    time_zone_q    <= pwdata[4:0];
				REG_COLON_ENABLE: colon_enable_q <= pwdata[0];
				REG_SCAN_DIVIDER: scan_divider_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_TIME_ZONE:    prdata = {27'd0, time_zone_q};
			REG_COLON_ENABLE: prdata = {31'd0, colon_enable_q};
			REG_SCAN_DIVIDER: prdata = {16'd0, scan_divider_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Time conversion pipeline
	csss_time_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tuser)),
		.in_value  (s_tdata[26:0]),
		.time_zone (time_zone_q),
		.out_valid (conv_valid),
		.out_ready (en_out),
		.out_item  (conv_item)
	);

	// Result register moves when empty or taken
	assign en_out = !out_vld_q || m_tready;
	assign upd    = en_out && conv_valid;

	// Prescaler and scan slot selection
	always_comb begin
		tick_nx    = tick_q + 16'd1;
		scan_step  = (tick_nx > scan_divider_q);
		scan_digit = 4'd0;
		if (32'(slot_q) < DIGIT_COUNT) begin
			scan_digit = digit_q[slot_q];
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en_out) begin
			out_vld_q <= conv_valid;
		end
	end

	// Display and time state, updated as each item is delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digit_q[i] <= 4'd0;
			end
			colon_q   <= 1'b0;
			hour_q    <= 5'd0;
			minute_q  <= 7'd0;
			second_q  <= 7'd0;
			slot_q    <= '0;
			tick_q    <= 16'd0;
			segment_q <= 8'd0;
			enable_q  <= 6'd0;
		end else if (upd) begin
			unique case (conv_item.cmd)
				CMD_LOAD: begin
					for (int i = 0; i < DIGIT_COUNT; i++) begin
						digit_q[i] <= conv_item.digits[i];
					end
					colon_q  <= conv_item.digits[5][0] & colon_enable_q;
					hour_q   <= conv_item.hours;
					minute_q <= conv_item.minutes;
					second_q <= conv_item.seconds;
				end
				CMD_TICK: begin
					if (scan_step) begin
						tick_q <= 16'd0;
						if (32'(slot_q) < DIGIT_COUNT) begin
							segment_q <= {colon_q, seg_pattern(scan_digit)};
							enable_q  <= 6'(6'd1 << slot_q);
							slot_q    <= SLOT_W'(slot_q + 1'b1);
						end else begin
							slot_q <= '0;
						end
					end else begin
						tick_q <= tick_nx;
					end
				end
				default: ;
			endcase
		end
	end

	// Result beat
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, second_q, minute_q, hour_q, enable_q, segment_q};

endmodule
